// File: design/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// Shared constants and types of the postfix digit evaluator.
// ----------------------------------------------------------------------------
package pde_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 31;
    localparam int OUT_W       = 32;
    localparam int SYM_W       = 8;

    localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE = 8'h39;
    localparam logic [SYM_W-1:0] SYM_PLUS = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;

    localparam logic [OUT_W-1:0] VALUE_ERR = 32'hFFFF_FFFF;

    // Stack cell operation
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD = 2'd0;
    localparam t_cell_op CELL_PUSH = 2'd1; // take neighbour above
    localparam t_cell_op CELL_POP  = 2'd2; // take neighbour below
    localparam t_cell_op CELL_LOAD = 2'd3; // take new value (head only)

    typedef logic [VAL_W-1:0] t_val;

endpackage

// File: design/postfix_digit_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_digit_evaluator_unit
// Reverse Polish evaluator for single digits, '+' and '*'.
// ----------------------------------------------------------------------------
// Input stream: one ASCII character per item in tdata, tlast on the final
// character of an expression. Output stream: one item per expression, the
// value in tdata (-1 on error) and the error flag in tuser.
// Throughput is one character per cycle while the skid slot is empty: the
// stack is a row of cells that shift together, and the head cell takes the
// add or multiply result in the same cycle. The result of a last character
// is registered in the main slot, or in the skid slot if the main is full.
// Reset clears the stack count, the error flag and both output slots; the
// stack cells themselves are not cleared. The output has a main register and
// a skid slot, so input items keep flowing while a result waits; the input
// stalls whenever the skid slot is full.
// Any error (bad character, underflow, stack full, result above 2^31-1) is
// sticky until the end of the expression.
// ----------------------------------------------------------------------------
module postfix_digit_evaluator_unit
    import pde_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [SYM_W-1:0] i_s_axis_tdata,  // [7:0] symbol
    input  logic             i_s_axis_tlast,  // last
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,  // [31:0] value
    output logic             o_m_axis_tuser   // [0] error
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_err, n_err;

    logic             r_m_valid;
    logic [OUT_W-1:0] r_m_value;
    logic             r_m_error;
    logic             r_sk_valid;
    logic [OUT_W-1:0] r_sk_value;
    logic             r_sk_error;

    t_val     w_val [STACK_DEPTH];
    t_cell_op w_head_op, w_body_op;
    t_val     w_load, n_head;
    t_val     w_res;
    logic     w_ovf;

    logic w_acc, w_digit, w_oper, w_push, w_reduce;
    logic w_produce, w_taken;
    logic [OUT_W-1:0] w_out_value;
    logic             w_out_error;

    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_digit = (i_s_axis_tdata >= SYM_ZERO) && (i_s_axis_tdata <= SYM_NINE);
    assign w_oper  = (i_s_axis_tdata == SYM_PLUS) || (i_s_axis_tdata == SYM_STAR);

    pde_alu u_alu (
        .i_a   (w_val[0]),
        .i_b   (w_val[1]),
        .i_mul (i_s_axis_tdata == SYM_STAR),
        .o_res (w_res),
        .o_ovf (w_ovf)
    );

    always_comb begin
        w_push   = 1'b0;
        w_reduce = 1'b0;
        n_err    = r_err;
        n_cnt    = r_cnt;
        if (w_acc && !r_err) begin
            if (w_digit) begin
                if (r_cnt >= CNT_W'(STACK_DEPTH)) begin
                    n_err = 1'b1;
                end else begin
                    w_push = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
            end else if (w_oper) begin
                if (r_cnt < CNT_W'(2) || w_ovf) begin
                    n_err = 1'b1;
                end else begin
                    w_reduce = 1'b1;
                    n_cnt    = r_cnt - 1'b1;
                end
            end else begin
                n_err = 1'b1;
            end
        end
    end

    always_comb begin
        w_load    = w_push ? {{(VAL_W-4){1'b0}}, i_s_axis_tdata[3:0]} : w_res;
        w_head_op = (w_push || w_reduce) ? CELL_LOAD : CELL_HOLD;
        w_body_op = w_push ? CELL_PUSH : (w_reduce ? CELL_POP : CELL_HOLD);
        n_head    = (w_push || w_reduce) ? w_load : w_val[0];
    end

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_val w_up, w_down;
        if (g == 0) begin : g_top
            assign w_up = '0;
        end else begin : g_mid
            assign w_up = w_val[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_down = '0;
        end else begin : g_nbot
            assign w_down = w_val[g+1];
        end
        pde_cell u_cell (
            .i_clk       (i_clk),
            .i_op        ((g == 0) ? w_head_op : w_body_op),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .i_load      (w_load),
            .o_val       (w_val[g])
        );
    end

    // Result of the expression just ended, from the post-update state
    assign w_produce   = w_acc && i_s_axis_tlast;
    assign w_out_error = n_err || (n_cnt == '0);
    assign w_out_value = w_out_error ? VALUE_ERR : {1'b0, n_head};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= 1'b0;
        end else if (w_produce) begin
            r_cnt <= '0;
            r_err <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_err <= n_err;
        end
    end

    assign w_taken = r_m_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (r_sk_valid) begin
            if (w_taken) begin
                r_m_value  <= r_sk_value;
                r_m_error  <= r_sk_error;
                r_sk_valid <= 1'b0;
            end
        end else if (w_produce) begin
            if (!r_m_valid || w_taken) begin
                r_m_valid <= 1'b1;
                r_m_value <= w_out_value;
                r_m_error <= w_out_error;
            end else begin
                r_sk_valid <= 1'b1;
                r_sk_value <= w_out_value;
                r_sk_error <= w_out_error;
            end
        end else if (w_taken) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_s_axis_tready = !r_sk_valid;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_value;
    assign o_m_axis_tuser  = r_m_error;

    // Assertions
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_m_valid)
        else $error("skid slot full while main slot empty");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_produce |=> (r_cnt == '0) && !r_err)
        else $error("state not cleared after last item");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_produce |=> o_m_axis_tvalid)
        else $error("result of last item not presented");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_error) |-> (r_m_value == VALUE_ERR))
        else $error("error result without -1 value");

endmodule

// File: design/pde_cell.sv
// ----------------------------------------------------------------------------
// pde_cell
// One stack entry; shifts with its neighbours on push and pop.
// ----------------------------------------------------------------------------
module pde_cell
    import pde_pkg::*;
(
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  t_val     i_from_up,
    input  t_val     i_from_down,
    input  t_val     i_load,
    output t_val     o_val
);

    t_val r_val;
    t_val n_val;

    always_comb begin
        case (i_op)
            CELL_HOLD: n_val = r_val;
            CELL_PUSH: n_val = i_from_up;
            CELL_POP:  n_val = i_from_down;
            CELL_LOAD: n_val = i_load;
            default:   n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// File: design/pde_alu.sv
// ----------------------------------------------------------------------------
// pde_alu
// Sum or product of the two top entries with an exact range check.
// ----------------------------------------------------------------------------
module pde_alu
    import pde_pkg::*;
(
    input  t_val i_a,
    input  t_val i_b,
    input  logic i_mul,
    output t_val o_res,
    output logic o_ovf
);

    logic [VAL_W:0]       w_sum;
    logic [2*VAL_W-1:0]   w_prod;

    assign w_sum  = {1'b0, i_a} + {1'b0, i_b};
    assign w_prod = i_a * i_b;

    always_comb begin
        if (i_mul) begin
            o_res = w_prod[VAL_W-1:0];
            o_ovf = |w_prod[2*VAL_W-1:VAL_W];
        end else begin
            o_res = w_sum[VAL_W-1:0];
            o_ovf = w_sum[VAL_W];
        end
    end

endmodule

// File: tb/sv/postfix_digit_evaluator_unit_tb.sv
// ----------------------------------------------------------------------------
// postfix_digit_evaluator_unit_tb
// Self-checking bench for the postfix digit evaluator. Whole expressions are
// streamed in: short hand-picked cases first, then random expressions of
// several kinds (well-formed, large values near the 2^31-1 boundary, deep
// stacks, long multiply chains, corrupted expressions and raw byte noise).
// A scoreboard evaluates every accepted symbol and checks each result, field
// by field, in order. Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
import pde_pkg::*;

typedef logic [SYM_W-1:0] t_sym;

typedef struct {
    logic [OUT_W-1:0] value;
    logic             error;
} t_expr_result;

localparam logic [63:0] VALUE_LIMIT = 64'h0000_0000_7FFF_FFFF;

class rpn_scoreboard;
    t_val         operands [STACK_DEPTH];
    int unsigned  n_operands;
    bit           fault;
    t_expr_result awaited [$];
    int unsigned  errors;

    function new();
        n_operands = 0;
        fault      = 1'b0;
        errors     = 0;
    endfunction

    function int unsigned pending();
        return awaited.size();
    endfunction

    // Evaluates one accepted symbol; returns 1 unless it was skipped after an error
    function bit note_symbol(t_sym sym, bit is_last);
        logic [63:0]  lhs;
        logic [63:0]  rhs;
        logic [63:0]  res;
        t_expr_result r;
        bit           used;
        used = !fault;
        if (!fault) begin
            if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
                if (n_operands >= STACK_DEPTH) begin
                    fault = 1'b1;
                end else begin
                    operands[n_operands] = t_val'(sym - SYM_ZERO);
                    n_operands++;
                end
            end else if (sym == SYM_PLUS || sym == SYM_STAR) begin
                if (n_operands < 2) begin
                    fault = 1'b1;
                end else begin
                    lhs = 64'(operands[n_operands-1]);
                    rhs = 64'(operands[n_operands-2]);
                    n_operands -= 2;
                    res = (sym == SYM_PLUS) ? lhs + rhs : lhs * rhs;
                    if (res > VALUE_LIMIT) begin
                        fault = 1'b1;
                    end else begin
                        operands[n_operands] = t_val'(res);
                        n_operands++;
                    end
                end
            end else begin
                fault = 1'b1;
            end
        end
        if (is_last) begin
            if (fault || n_operands == 0) begin
                r.value = VALUE_ERR;
                r.error = 1'b1;
            end else begin
                r.value = {1'b0, operands[n_operands-1]};
                r.error = 1'b0;
            end
            awaited.push_back(r);
            n_operands = 0;
            fault      = 1'b0;
        end
        return used;
    endfunction

    function void check_result(logic [OUT_W-1:0] value, logic error);
        t_expr_result r;
        if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual value %h error %b",
                     $time, value, error);
        end else begin
            r = awaited.pop_front();
            if (value !== r.value) begin
                errors++;
                $display("%0t: value mismatch: expected %h, actual %h",
                         $time, r.value, value);
            end
            if (error !== r.error) begin
                errors++;
                $display("%0t: error flag mismatch: expected %b, actual %b",
                         $time, r.error, error);
            end
        end
    endfunction
endclass

module postfix_digit_evaluator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_COUNT  = 1700;
    localparam int STALL_LIMIT = 2000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [SYM_W-1:0] i_s_axis_tdata = '0;   // [7:0] symbol
    logic             i_s_axis_tlast = 1'b0; // last
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;        // [31:0] value
    logic             o_m_axis_tuser;        // [0] error

    rpn_scoreboard sb;
    t_sym          expr_chars [$];
    int unsigned   items_used = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   ready_hold = 0;
    bit            idle_on = 1'b1;

    postfix_digit_evaluator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Monitor: results are checked before the same edge's symbol is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                void'(sb.note_symbol(i_s_axis_tdata, i_s_axis_tlast));
                items_used++;
            end
        end
    end

    // Receiver with random stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (ready_hold != 0) begin
                ready_hold--;
                i_m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                ready_hold = $urandom_range(1, 5) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[postfix_digit_evaluator_unit] ERROR");
            $finish;
        end
    end

    task automatic send_symbol(input t_sym sym, input bit is_last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= t_sym'($urandom);
            i_s_axis_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= sym;
        i_s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_expr();
        foreach (expr_chars[i]) begin
            send_symbol(expr_chars[i], i == expr_chars.size() - 1);
        end
        expr_chars.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) expr_chars.push_back(t_sym'(s[i]));
        send_expr();
    endtask

    // Waits with the sender idle until every awaited result has come
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic t_sym digit(input int unsigned d);
        return t_sym'(SYM_ZERO + d);
    endfunction

    function automatic t_sym any_op();
        return $urandom_range(0, 1) ? SYM_PLUS : SYM_STAR;
    endfunction

    // Builds n from single digits in base nine: d0 9 * d1 + 9 * d2 + ...
    task automatic append_value(input int unsigned n);
        int unsigned dig [$];
        do begin
            dig.push_front(n % 9);
            n = n / 9;
        end while (n != 0);
        expr_chars.push_back(digit(dig[0]));
        for (int i = 1; i < dig.size(); i++) begin
            expr_chars.push_back(digit(9));
            expr_chars.push_back(SYM_STAR);
            if (dig[i] != 0) begin
                expr_chars.push_back(digit(dig[i]));
                expr_chars.push_back(SYM_PLUS);
            end
        end
    endtask

    task automatic gen_well_formed(input int unsigned n_digits);
        int unsigned depth  = 0;
        int unsigned pushed = 0;
        while (!(pushed == n_digits && depth == 1)) begin
            if (pushed < n_digits && (depth < 2 || $urandom_range(0, 1))) begin
                expr_chars.push_back(digit($urandom_range(0, 9)));
                pushed++;
                depth++;
            end else begin
                expr_chars.push_back(any_op());
                depth--;
            end
        end
    endtask

    task automatic gen_large_value();
        case ($urandom_range(0, 3))
            0: begin
                append_value(32'h7FFF_FFFF - $urandom_range(0, 12));
                expr_chars.push_back(digit($urandom_range(0, 9)));
                expr_chars.push_back(SYM_PLUS);
            end
            1: begin
                append_value($urandom_range(32'h7FFF_FFFF / 9 - 8, 32'h7FFF_FFFF));
                expr_chars.push_back(digit($urandom_range(0, 9)));
                expr_chars.push_back(SYM_STAR);
            end
            2: begin
                append_value($urandom_range(0, 32'h7FFF_FFFF));
                append_value($urandom_range(0, 32'h7FFF_FFFF));
                expr_chars.push_back(SYM_PLUS);
            end
            default: begin
                // products straddling the 2^31-1 boundary
                append_value($urandom_range(30000, 70000));
                append_value($urandom_range(30000, 70000));
                expr_chars.push_back(SYM_STAR);
            end
        endcase
    endtask

    task automatic gen_deep_stack();
        int unsigned n_digits = STACK_DEPTH - 2 + $urandom_range(0, 4);
        for (int i = 0; i < n_digits; i++) expr_chars.push_back(digit($urandom_range(0, 9)));
        for (int i = 1; i < n_digits; i++) begin
            expr_chars.push_back($urandom_range(0, 3) ? SYM_PLUS : SYM_STAR);
        end
    endtask

    task automatic gen_chain();
        int unsigned d = $urandom_range(2, 9);
        expr_chars.push_back(digit(d));
        repeat ($urandom_range(1, 32)) begin
            expr_chars.push_back(digit(d));
            expr_chars.push_back($urandom_range(0, 5) ? SYM_STAR : SYM_PLUS);
        end
    endtask

    task automatic gen_broken();
        t_sym bad [4] = '{8'h2F, 8'h3A, 8'h2C, 8'h2D};
        gen_well_formed($urandom_range(1, 6));
        case ($urandom_range(0, 3))
            0: expr_chars[$urandom_range(0, expr_chars.size() - 1)] = t_sym'($urandom);
            1: expr_chars.push_front(any_op());
            2: expr_chars.push_back(digit($urandom_range(0, 9)));
            default: expr_chars.insert($urandom_range(0, expr_chars.size()),
                                       bad[$urandom_range(0, 3)]);
        endcase
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 6)) expr_chars.push_back(t_sym'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned n_expr = 0;
        int unsigned kind;
        bit          drained = 1'b0;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-picked cases
        send_text("0");
        send_text("9");
        send_text("78*9+");
        send_text("+");           // operator with too few operands
        send_text("4*");
        send_text("2x3+");        // unknown character, rest ignored
        send_text("56");          // two left on the stack, top is returned
        expr_chars.push_back(8'hFF);
        send_expr();
        expr_chars.push_back(8'h00);
        expr_chars.push_back(digit(7));
        send_expr();
        expr_chars.push_back(8'h80);
        send_expr();

        while (items_used < ITEM_COUNT) begin
            if (items_used > ITEM_COUNT * 85 / 100) begin
                idle_on = 1'b0;
            end else begin
                idle_on = ($urandom_range(0, 5) != 0);
            end
            if (!drained && items_used > ITEM_COUNT / 2) begin
                drain_results();
                drained = 1'b1;
            end
            kind = (n_expr < 6) ? n_expr : $urandom_range(0, 99) % 10;
            case (kind)
                1, 6:    gen_large_value();
                2:       gen_deep_stack();
                3, 7:    gen_broken();
                4:       gen_noise();
                5:       gen_chain();
                default: gen_well_formed($urandom_range(1, 8));
            endcase
            send_expr();
            n_expr++;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[postfix_digit_evaluator_unit] OK");
        end else begin
            $display("[postfix_digit_evaluator_unit] ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
design/pde_pkg.sv
design/pde_cell.sv
design/pde_alu.sv
design/postfix_digit_evaluator_unit.sv
tb/sv/postfix_digit_evaluator_unit_tb.sv
